FILE: rtl/core/pad_pkg.sv
`timescale 1ns / 1ps

package pad_pkg;

	// Fixed point format of all external values
	localparam int FRAC_BITS = 16;

	// Horner chain: one cell per series term
	localparam int N_CELLS    = 8;
	localparam int CELL_IDX_W = $clog2(N_CELLS);
	localparam int DIV_STEPS  = 32;

	// Pipeline depths in registers
	localparam int SC_LAT    = 5 + 3 * N_CELLS;
	localparam int DIV_LAT   = 3 + DIV_STEPS;
	localparam int TOTAL_LAT = SC_LAT + 2 * DIV_LAT + 1;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;
	localparam logic signed [31:0] Q30_ONE = 32'sh40000000;

	// Quadrant codes
	localparam logic [1:0] QUAD0 = 2'd0;
	localparam logic [1:0] QUAD1 = 2'd1;
	localparam logic [1:0] QUAD2 = 2'd2;
	localparam logic [1:0] QUAD3 = 2'd3;

	typedef logic [CELL_IDX_W-1:0] cidx_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ROLL_GAIN_REF   = 3'd0,
		REG_ROLL_GAIN_ANGLE = 3'd1,
		REG_ROLL_GAIN_RATE  = 3'd2,
		REG_GRAVITY         = 3'd3,
		REG_AIRSPEED        = 3'd4
	} cfg_reg_t;

	// Item travelling down the Horner chain
	typedef struct packed {
		logic [31:0]        s;
		logic [30:0]        a;
		logic [1:0]         quad;
		logic signed [31:0] ts;
		logic signed [31:0] tc;
	} hrn_t;

	// Item travelling down the divider chain
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] sh;
		logic [31:0] d;
		logic        neg;
		logic        ovf;
	} dvs_t;

	// Sine series divisors, last cell idle
	function automatic logic [7:0] sin_div(input cidx_t idx);
		case (idx)
			3'd0: return 8'd210;
			3'd1: return 8'd156;
			3'd2: return 8'd110;
			3'd3: return 8'd72;
			3'd4: return 8'd42;
			3'd5: return 8'd20;
			default: return 8'd6;
		endcase
	endfunction

	// floor(2^34 / divisor)
	function automatic logic [33:0] sin_rcp(input cidx_t idx);
		case (idx)
			3'd0: return 34'd81808900;
			3'd1: return 34'd110127366;
			3'd2: return 34'd156180628;
			3'd3: return 34'd238609294;
			3'd4: return 34'd409044504;
			3'd5: return 34'd858993459;
			default: return 34'd2863311530;
		endcase
	endfunction

	function automatic logic sin_on(input cidx_t idx);
		return idx != cidx_t'(N_CELLS - 1);
	endfunction

	function automatic logic [7:0] cos_div(input cidx_t idx);
		case (idx)
			3'd0: return 8'd240;
			3'd1: return 8'd182;
			3'd2: return 8'd132;
			3'd3: return 8'd90;
			3'd4: return 8'd56;
			3'd5: return 8'd30;
			3'd6: return 8'd12;
			default: return 8'd2;
		endcase
	endfunction

	function automatic logic [33:0] cos_rcp(input cidx_t idx);
		case (idx)
			3'd0: return 34'd71582788;
			3'd1: return 34'd94394885;
			3'd2: return 34'd130150524;
			3'd3: return 34'd190887435;
			3'd4: return 34'd306783378;
			3'd5: return 34'd572662306;
			3'd6: return 34'd1431655765;
			default: return 34'd8589934592;
		endcase
	endfunction

	// Quotient estimate correction, sign restore and 1 - q
	function automatic logic signed [31:0] hrn_finish(input logic [33:0] ax,
			input logic [33:0] qe, input logic neg, input logic [7:0] d);
		logic [41:0]        qd;
		logic [41:0]        r;
		logic [33:0]        q;
		logic signed [35:0] tq;
		qd = 42'(qe) * 42'(d);
		r  = 42'(ax) - qd;
		q  = (r >= 42'(d)) ? qe + 34'd1 : qe;
		tq = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
		return 32'(36'(Q30_ONE) - tq);
	endfunction

	// Saturate to 32 bit signed
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v[65:31] == '0 || v[65:31] == '1)
			return v[31:0];
		return v[65] ? S32_MIN : S32_MAX;
	endfunction

endpackage

FILE: rtl/core/planar_aircraft_dynamics.sv
`timescale 1ns / 1ps
// Pipeline: 29-stage sine/cosine, two 35-stage dividers for tan and turn rate,
// one multiply stage between them.
// Takes one item per clock; busy is never raised.
// Reset clears the result strobe pipeline and loads the register defaults.
// The receiver cannot stall: each result shows for one cycle with strobe.
module planar_aircraft_dynamics (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] roll_angle,
	input  logic signed [31:0] roll_rate,
	input  logic signed [31:0] heading,
	input  logic signed [31:0] roll_ref,
	input  logic signed [31:0] wind_north,
	input  logic signed [31:0] wind_east,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               strobe,
	output logic signed [31:0] roll_rate_out,
	output logic signed [31:0] roll_accel,
	output logic signed [31:0] heading_rate,
	output logic signed [31:0] north_speed,
	output logic signed [31:0] east_speed
);
	import pad_pkg::*;

	localparam int ACC_DLY = TOTAL_LAT - 2;
	localparam int HDG_DLY = TOTAL_LAT - SC_LAT - 2;
	localparam int WND_DLY = SC_LAT + 1;

	logic signed [31:0] gain_ref_q, gain_angle_q, gain_rate_q;
	logic [30:0]        gravity_q, airspeed_q;
	logic               accept;
	logic [TOTAL_LAT-1:0] vld_q;

	logic signed [63:0] p0_s1, p1_s1, p2_s1;
	logic signed [65:0] acc_sum;
	logic signed [31:0] acc_s2;

	logic signed [31:0] rsn, rcs, hsn, hcs, tanv, rate;
	logic signed [63:0] gt_s1;
	logic signed [31:0] as_den;

	logic signed [62:0] np, ep;
	logic signed [62:0] np_s1, ep_s1;
	logic signed [65:0] nsum, esum;
	logic signed [31:0] north_s2, east_s2;

	logic signed [31:0] dphi_q  [TOTAL_LAT];
	logic signed [31:0] acc_q   [ACC_DLY];
	logic signed [31:0] north_q [HDG_DLY];
	logic signed [31:0] east_q  [HDG_DLY];
	logic signed [31:0] wn_q    [WND_DLY];
	logic signed [31:0] we_q    [WND_DLY];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_ref_q   <= '0;
			gain_angle_q <= '0;
			gain_rate_q  <= '0;
			gravity_q    <= 31'd642689;
			airspeed_q   <= 31'd983040;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROLL_GAIN_REF:   gain_ref_q   <= $signed(cfg_data);
				REG_ROLL_GAIN_ANGLE: gain_angle_q <= $signed(cfg_data);
				REG_ROLL_GAIN_RATE:  gain_rate_q  <= $signed(cfg_data);
				REG_GRAVITY:         gravity_q    <= cfg_data[30:0];
				REG_AIRSPEED:        airspeed_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// item strobe pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[TOTAL_LAT-2:0], accept};
	end

	// roll acceleration: three products, one floored sum
	always_ff @(posedge clk) begin
		p0_s1 <= 64'(gain_ref_q) * 64'(roll_ref);
		p1_s1 <= 64'(gain_angle_q) * 64'(roll_angle);
		p2_s1 <= 64'(gain_rate_q) * 64'(roll_rate);
	end

	assign acc_sum = 66'(p0_s1) - 66'(p1_s1) - 66'(p2_s1);

	always_ff @(posedge clk) begin
		acc_s2 <= sat32(66'(acc_sum >>> FRAC_BITS));
	end

	// turn rate: tan by division, then gravity over airspeed
	pad_sincos u_roll_sc (
		.clk (clk),
		.x   (roll_angle),
		.sn  (rsn),
		.cs  (rcs)
	);

	pad_divider u_tan_div (
		.clk (clk),
		.num (64'(rsn) <<< FRAC_BITS),
		.den (rcs),
		.quo (tanv)
	);

	always_ff @(posedge clk) begin
		gt_s1 <= 64'($signed({1'b0, gravity_q})) * 64'(tanv);
	end

	assign as_den = (airspeed_q == '0) ? 32'sd1 : $signed({1'b0, airspeed_q});

	pad_divider u_rate_div (
		.clk (clk),
		.num (gt_s1),
		.den (as_den),
		.quo (rate)
	);

	// ground speeds
	pad_sincos u_hdg_sc (
		.clk (clk),
		.x   (heading),
		.sn  (hsn),
		.cs  (hcs)
	);

	assign np = 63'($signed({1'b0, airspeed_q})) * 63'(hcs);
	assign ep = 63'($signed({1'b0, airspeed_q})) * 63'(hsn);

	always_ff @(posedge clk) begin
		np_s1 <= np;
		ep_s1 <= ep;
	end

	assign nsum = 66'(np_s1 >>> 30) + 66'(wn_q[WND_DLY-1]);
	assign esum = 66'(ep_s1 >>> 30) + 66'(we_q[WND_DLY-1]);

	always_ff @(posedge clk) begin
		north_s2 <= sat32(nsum);
		east_s2  <= sat32(esum);
	end

	// alignment delay lines
	always_ff @(posedge clk) begin
		dphi_q[0]  <= roll_rate;
		acc_q[0]   <= acc_s2;
		north_q[0] <= north_s2;
		east_q[0]  <= east_s2;
		wn_q[0]    <= wind_north;
		we_q[0]    <= wind_east;
		for (int k = 1; k < TOTAL_LAT; k++)
			dphi_q[k] <= dphi_q[k-1];
		for (int k = 1; k < ACC_DLY; k++)
			acc_q[k] <= acc_q[k-1];
		for (int k = 1; k < HDG_DLY; k++) begin
			north_q[k] <= north_q[k-1];
			east_q[k]  <= east_q[k-1];
		end
		for (int k = 1; k < WND_DLY; k++) begin
			wn_q[k] <= wn_q[k-1];
			we_q[k] <= we_q[k-1];
		end
	end

	assign strobe        = vld_q[TOTAL_LAT-1];
	assign roll_rate_out = dphi_q[TOTAL_LAT-1];
	assign roll_accel    = acc_q[ACC_DLY-1];
	assign heading_rate  = rate;
	assign north_speed   = north_q[HDG_DLY-1];
	assign east_speed    = east_q[HDG_DLY-1];

endmodule

FILE: rtl/core/pad_horner_cell.sv
`timescale 1ns / 1ps

module pad_horner_cell (
	input  logic             clk,
	input  pad_pkg::cidx_t   idx,
	input  pad_pkg::hrn_t    din,
	output pad_pkg::hrn_t    dout
);
	import pad_pkg::*;

	logic signed [64:0] ps, pc;
	logic signed [34:0] xs_s1, xc_s1;
	hrn_t               h_s1, h_s2;
	logic [33:0]        axs, axc;
	logic [67:0]        ms, mc;
	logic [33:0]        axs_s2, axc_s2, qs_s2, qc_s2;
	logic               ns_s2, nc_s2;

	// s*t, floor shifted back to Q30
	assign ps = 65'($signed({1'b0, din.s})) * 65'(din.ts);
	assign pc = 65'($signed({1'b0, din.s})) * 65'(din.tc);

	always_ff @(posedge clk) begin
		xs_s1 <= ps[64:30];
		xc_s1 <= pc[64:30];
		h_s1  <= din;
	end

	// magnitude times reciprocal gives quotient or one below
	assign axs = xs_s1[34] ? 34'(-xs_s1) : 34'(xs_s1);
	assign axc = xc_s1[34] ? 34'(-xc_s1) : 34'(xc_s1);
	assign ms  = 68'(axs) * 68'(sin_rcp(idx));
	assign mc  = 68'(axc) * 68'(cos_rcp(idx));

	always_ff @(posedge clk) begin
		axs_s2 <= axs;
		axc_s2 <= axc;
		qs_s2  <= ms[67:34];
		qc_s2  <= mc[67:34];
		ns_s2  <= xs_s1[34];
		nc_s2  <= xc_s1[34];
		h_s2   <= h_s1;
	end

	// correct, truncate toward zero, next term
	always_ff @(posedge clk) begin
		dout.s    <= h_s2.s;
		dout.a    <= h_s2.a;
		dout.quad <= h_s2.quad;
		dout.ts   <= sin_on(idx) ? hrn_finish(axs_s2, qs_s2, ns_s2, sin_div(idx)) : h_s2.ts;
		dout.tc   <= hrn_finish(axc_s2, qc_s2, nc_s2, cos_div(idx));
	end

endmodule

FILE: rtl/core/pad_sincos.sv
`timescale 1ns / 1ps

module pad_sincos (
	input  logic               clk,
	input  logic signed [31:0] x,
	output logic signed [31:0] sn,
	output logic signed [31:0] cs
);
	import pad_pkg::*;

	logic signed [62:0] php;
	logic [31:0]        phase_s1;
	logic [61:0]        ap, sp;
	logic [30:0]        a_s2, a_s3;
	logic [1:0]         quad_s2, quad_s3, quad_s4;
	logic [31:0]        s_s3;
	hrn_t               chain [N_CELLS+1];
	hrn_t               e;
	logic signed [63:0] sap;
	logic signed [31:0] sa_s4, ca_s4;

	// angle to phase in 2^-32 turn
	assign php = 63'(x) * 63'sd683565276;

	always_ff @(posedge clk) begin
		phase_s1 <= php[FRAC_BITS+31:FRAC_BITS];
	end

	// quadrant offset to Q30 radians
	assign ap = 62'(phase_s1[29:0]) * 62'd3373259426;

	always_ff @(posedge clk) begin
		a_s2    <= ap[61:31];
		quad_s2 <= phase_s1[31:30];
	end

	// a squared
	assign sp = 62'(a_s2) * 62'(a_s2);

	always_ff @(posedge clk) begin
		s_s3    <= sp[61:30];
		a_s3    <= a_s2;
		quad_s3 <= quad_s2;
	end

	assign chain[0] = '{s: s_s3, a: a_s3, quad: quad_s3, ts: Q30_ONE, tc: Q30_ONE};

	genvar i;
	for (i = 0; i < N_CELLS; i++) begin : g_cell
		pad_horner_cell u_cell (
			.clk  (clk),
			.idx  (cidx_t'(i)),
			.din  (chain[i]),
			.dout (chain[i+1])
		);
	end

	// sine = a*t, cosine clamped at zero
	assign e   = chain[N_CELLS];
	assign sap = 64'($signed({1'b0, e.a})) * 64'(e.ts);

	always_ff @(posedge clk) begin
		sa_s4   <= sap[61:30];
		ca_s4   <= e.tc[31] ? '0 : e.tc;
		quad_s4 <= e.quad;
	end

	// quadrant rotation
	always_ff @(posedge clk) begin
		case (quad_s4)
			QUAD0: begin
				sn <= sa_s4;
				cs <= ca_s4;
			end
			QUAD1: begin
				sn <= ca_s4;
				cs <= -sa_s4;
			end
			QUAD2: begin
				sn <= -sa_s4;
				cs <= -ca_s4;
			end
			default: begin
				sn <= -ca_s4;
				cs <= sa_s4;
			end
		endcase
	end

endmodule

FILE: rtl/core/pad_div_cell.sv
`timescale 1ns / 1ps

module pad_div_cell (
	input  logic          clk,
	input  pad_pkg::dvs_t din,
	output pad_pkg::dvs_t dout
);
	import pad_pkg::*;

	logic [32:0] rem_x, diff;
	logic        ge;

	// one restoring step: shift in a dividend bit, try subtract
	assign rem_x = {din.rem, din.sh[31]};
	assign ge    = rem_x >= {1'b0, din.d};
	assign diff  = rem_x - {1'b0, din.d};

	always_ff @(posedge clk) begin
		dout.rem <= ge ? diff[31:0] : rem_x[31:0];
		dout.sh  <= {din.sh[30:0], ge};
		dout.d   <= din.d;
		dout.neg <= din.neg;
		dout.ovf <= din.ovf;
	end

endmodule

FILE: rtl/core/pad_divider.sv
`timescale 1ns / 1ps

module pad_divider (
	input  logic               clk,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output logic signed [31:0] quo
);
	import pad_pkg::*;

	logic        neg_s1;
	logic [63:0] an_s1;
	logic [31:0] ad_s1;
	dvs_t        chain [DIV_STEPS+1];
	dvs_t        e;

	// sign and magnitudes
	always_ff @(posedge clk) begin
		neg_s1 <= num[63] ^ den[31];
		an_s1  <= num[63] ? 64'(-num) : 64'(num);
		ad_s1  <= den[31] ? 32'(-den) : 32'(den);
	end

	// quotient beyond 32 bits or zero divisor saturates
	always_ff @(posedge clk) begin
		chain[0].rem <= an_s1[63:32];
		chain[0].sh  <= an_s1[31:0];
		chain[0].d   <= ad_s1;
		chain[0].neg <= neg_s1;
		chain[0].ovf <= (ad_s1 == '0) || (an_s1[63:32] >= ad_s1);
	end

	genvar i;
	for (i = 0; i < DIV_STEPS; i++) begin : g_step
		pad_div_cell u_step (
			.clk  (clk),
			.din  (chain[i]),
			.dout (chain[i+1])
		);
	end

	// signed result with saturation
	assign e = chain[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (e.ovf)
			quo <= e.neg ? S32_MIN : S32_MAX;
		else if (e.neg)
			quo <= (e.sh > 32'h80000000) ? S32_MIN : -$signed(e.sh);
		else
			quo <= e.sh[31] ? S32_MAX : $signed(e.sh);
	end

endmodule
